>>> rtl/sgd_pkg.sv
// Shared types, constants and helper functions for the shake gesture detector.
// No dependencies; the front end, queue, back end and top module import this package.
`default_nettype none

package sgd_pkg;

   // Widths of the configuration port, magnitudes and time.
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int MG_W       = 14;
   localparam int MAG_W      = 15;
   localparam int CMP_W      = 17;
   localparam int TIME_W     = 32;
   localparam int COOL_W     = 16;
   localparam int ACT_W      = 2;

   // Entries in the queue between classifier and state machine.
   localparam int QDEPTH = 2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_HORIZ_THR    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_VERT_THR     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DEPTH_THR    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_HORIZ_MARGIN = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_VERT_MARGIN  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_DEPTH_MARGIN = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_REARM        = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_COOLDOWN     = 3'd7;

   // Action codes.
   localparam logic [ACT_W-1:0] ACT_NONE     = 2'd0;
   localparam logic [ACT_W-1:0] ACT_INCREASE = 2'd1;
   localparam logic [ACT_W-1:0] ACT_DECREASE = 2'd2;
   localparam logic [ACT_W-1:0] ACT_SWITCH   = 2'd3;

   // The depth axis needs this much more than its programmed values.
   localparam logic [CMP_W-1:0] DEPTH_EXTRA_THR    = 17'd1800;
   localparam logic [CMP_W-1:0] DEPTH_EXTRA_MARGIN = 17'd900;

   // Register values after reset.
   localparam logic [MG_W-1:0]   RST_THR     = 14'd1500;
   localparam logic [MG_W-1:0]   RST_MARGIN  = 14'd500;
   localparam logic [MG_W-1:0]   RST_REARM   = 14'd1100;
   localparam logic [COOL_W-1:0] RST_COOLDOWN = 16'd700;

   typedef struct packed {
      logic [MG_W-1:0]   horiz_thr;
      logic [MG_W-1:0]   vert_thr;
      logic [MG_W-1:0]   depth_thr;
      logic [MG_W-1:0]   horiz_margin;
      logic [MG_W-1:0]   vert_margin;
      logic [MG_W-1:0]   depth_margin;
      logic [MG_W-1:0]   rearm;
      logic [COOL_W-1:0] cooldown;
   } cfg_type;

   // One classified sample as it travels from the front end to the back end.
   typedef struct packed {
      logic              suppress;
      logic              any_strong;
      logic              rearm;
      logic [ACT_W-1:0]  action;
      logic [TIME_W-1:0] time_ms;
   } cls_type;

   // Magnitude of a 15-bit two's complement value; the most negative code gives 16384.
   function automatic logic [MAG_W-1:0] mag_fn(input logic [MAG_W-1:0] raw);
      logic [MAG_W-1:0] neg;
      neg = ~raw + 15'd1;
      return raw[MAG_W-1] ? neg : raw;
   endfunction

   // True when axis a reaches thr and beats b and c by more than margin.
   function automatic logic dom_fn(input logic [MAG_W-1:0] a,
                                   input logic [CMP_W-1:0] thr,
                                   input logic [CMP_W-1:0] margin,
                                   input logic [MAG_W-1:0] b,
                                   input logic [MAG_W-1:0] c);
      logic [CMP_W-1:0] a_x;
      logic [CMP_W-1:0] b_sum;
      logic [CMP_W-1:0] c_sum;
      a_x   = {2'b00, a};
      b_sum = {2'b00, b} + margin;
      c_sum = {2'b00, c} + margin;
      return (a_x >= thr) && (a_x > b_sum) && (a_x > c_sum);
   endfunction

endpackage

`default_nettype wire

>>> rtl/sgd_ifs.sv
// Channel interfaces of the shake gesture detector: sample requests and action responses.
// Depends on nothing; ports use plain vectors at the field widths.
`default_nettype none

interface sgd_req_if;
   logic               valid;
   logic               ready;
   logic signed [14:0] accel_x;
   logic signed [14:0] accel_y;
   logic signed [14:0] accel_z;
   logic [31:0]        time_ms;
   logic               portrait;
   logic               suppress;

   modport source (output valid, accel_x, accel_y, accel_z, time_ms, portrait, suppress,
                   input ready);
   modport sink   (input valid, accel_x, accel_y, accel_z, time_ms, portrait, suppress,
                   output ready);
endinterface

interface sgd_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] action;

   modport source (output valid, action, input ready);
   modport sink   (input valid, action, output ready);
endinterface

`default_nettype wire

>>> rtl/sgd_front.sv
// Front end: accepts sample transactions and classifies each one against the thresholds.
// Depends on sgd_pkg and sgd_req_if; pushes one classified entry per transaction.
`default_nettype none

module sgd_front #(
   parameter bit DEPTH_ENABLED = 1'b1
) (
   input  sgd_pkg::cfg_type cfg,
   sgd_req_if.sink          req_chan,
   input  logic             q_full,
   output logic             q_push,
   output sgd_pkg::cls_type q_data
);
   import sgd_pkg::*;

   logic [MAG_W-1:0] mx, my, mz, mh, mv;
   logic [CMP_W-1:0] d_thr, d_margin;
   logic             strong_h, strong_v, strong_d;
   logic             below;

   // Axis magnitudes, with x and y swapped in portrait.
   assign mx = mag_fn(req_chan.accel_x);
   assign my = mag_fn(req_chan.accel_y);
   assign mz = mag_fn(req_chan.accel_z);
   assign mh = req_chan.portrait ? my : mx;
   assign mv = req_chan.portrait ? mx : my;

   // Dominance tests per direction.
   assign d_thr    = {3'b000, cfg.depth_thr} + DEPTH_EXTRA_THR;
   assign d_margin = {3'b000, cfg.depth_margin} + DEPTH_EXTRA_MARGIN;
   assign strong_h = dom_fn(mh, {3'b000, cfg.horiz_thr}, {3'b000, cfg.horiz_margin}, mv, mz);
   assign strong_v = dom_fn(mv, {3'b000, cfg.vert_thr}, {3'b000, cfg.vert_margin}, mh, mz);
   assign strong_d = DEPTH_ENABLED && dom_fn(mz, d_thr, d_margin, mx, my);

   // All three magnitudes below the rearm level.
   assign below = ({1'b0, cfg.rearm} > mx) && ({1'b0, cfg.rearm} > my) &&
                  ({1'b0, cfg.rearm} > mz);

   // Classified entry: flags for the back end and the action that a firing would produce.
   always_comb begin
      q_data.suppress   = req_chan.suppress;
      q_data.any_strong = strong_h || strong_v || strong_d;
      q_data.rearm      = below;
      q_data.time_ms    = req_chan.time_ms;
      if (strong_d && (mz >= mx) && (mz >= my)) begin
         q_data.action = ACT_SWITCH;
      end else if (strong_h && (!strong_v || (mh >= mv))) begin
         q_data.action = ACT_INCREASE;
      end else begin
         q_data.action = ACT_DECREASE;
      end
   end

   // Handshake toward the queue.
   assign req_chan.ready = !q_full;
   assign q_push         = req_chan.valid && !q_full;

endmodule

`default_nettype wire

>>> rtl/sgd_queue.sv
// Short first-in first-out queue of classified samples between front end and back end.
// Depends on sgd_pkg for the entry type and depth.
`default_nettype none

module sgd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  sgd_pkg::cls_type push_data,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output sgd_pkg::cls_type head_data
);
   import sgd_pkg::*;

   localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int CNT_W = $clog2(QDEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QDEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QDEPTH);

   cls_type            entry_ff [QDEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full       = (count_ff == CNT_FULL);
   assign head_valid = (count_ff != '0);
   assign head_data  = entry_ff[rd_ptr_ff];

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

>>> rtl/sgd_back.sv
// Back end: applies rearm, cooldown and firing state to classified samples in order.
// Depends on sgd_pkg and sgd_rsp_if; holds the action in a registered output stage.
`default_nettype none

module sgd_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [sgd_pkg::COOL_W-1:0]  cooldown,
   input  logic                        head_valid,
   input  sgd_pkg::cls_type            head_data,
   output logic                        pop,
   sgd_rsp_if.source                   rsp_chan
);
   import sgd_pkg::*;

   logic              armed_ff, armed_in;
   logic [TIME_W-1:0] last_fire_ff, last_fire_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [ACT_W-1:0]  action_ff, action_in;
   logic [TIME_W-1:0] elapsed;
   logic              armed_now;
   logic              fire;

   // Take the head entry whenever the output stage is free or being emptied.
   assign pop = head_valid && (!rsp_valid_ff || rsp_chan.ready);

   // Rearm applies before the trigger test; elapsed time wraps modulo 2^32.
   assign elapsed   = head_data.time_ms - last_fire_ff;
   assign armed_now = armed_ff || head_data.rearm;
   assign fire      = !head_data.suppress && armed_now && head_data.any_strong &&
                      (elapsed >= {16'h0000, cooldown});

   // Next state and output stage.
   always_comb begin
      armed_in     = armed_ff;
      last_fire_in = last_fire_ff;
      rsp_valid_in = rsp_valid_ff;
      action_in    = action_ff;
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (pop) begin
         rsp_valid_in = 1'b1;
         action_in    = fire ? head_data.action : ACT_NONE;
         if (!head_data.suppress) begin
            armed_in = fire ? 1'b0 : armed_now;
         end
         if (fire) begin
            last_fire_in = head_data.time_ms;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff     <= 1'b1;
         last_fire_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         armed_ff     <= armed_in;
         last_fire_ff <= last_fire_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff <= action_in;
   end

   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.action = action_ff;

`ifndef SYNTH
   // A firing disarms the detector and records its timestamp.
   a_fire_disarms : assert property (@(posedge clock) disable iff (reset)
      (pop && fire) |=> (!armed_ff && last_fire_ff == $past(head_data.time_ms)))
      else $error("firing did not disarm or record its time");

   // A suppressed sample leaves the state untouched and reports no action.
   a_suppress_holds : assert property (@(posedge clock) disable iff (reset)
      (pop && head_data.suppress) |=>
         ($stable(armed_ff) && $stable(last_fire_ff) && action_ff == ACT_NONE))
      else $error("suppressed sample changed state or reported an action");

   // Only a firing may report an action other than none.
   a_action_needs_fire : assert property (@(posedge clock) disable iff (reset)
      (pop && !fire) |=> (action_ff == ACT_NONE && $stable(last_fire_ff)))
      else $error("action reported without a firing");
`endif

endmodule

`default_nettype wire

>>> rtl/shake_gesture_detector_top.sv
// Shake gesture detector: one action per accelerometer sample transaction.
// Request channel: req_chan carries accel_x/y/z, time_ms, portrait and suppress.
// Response channel: rsp_chan carries action (none, increase, decrease, switch mode).
// Configuration: csr_we writes csr_wdata into register csr_index at the clock edge;
//   write only while the block holds no sample in flight.
// Path: an accepted sample enters the queue, and the back end registers its response.
// Throughput: one sample per cycle unless rsp_chan stalls; the classifier handles a
//   sample in the cycle it is accepted; the state stage retires one entry per cycle.
// Stalls: a two-entry queue sits between the classifier and the state stage, so
//   req_chan.ready only drops once the queue is full while rsp_chan is stalled.
// Reset: synchronous, active high; registers return to defaults, the detector
//   is armed, the last firing time is zero and the queue is empty.
`default_nettype none

module shake_gesture_detector_top #(
   parameter bit DEPTH_ENABLED = 1'b1
) (
   input  logic                              clock,
   input  logic                              reset,
   sgd_req_if.sink                           req_chan,
   sgd_rsp_if.source                         rsp_chan,
   input  logic                              csr_we,
   input  logic [sgd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [sgd_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import sgd_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    q_full, q_push, q_pop, q_valid;
   cls_type q_in_data, q_head;

   // Configuration register writes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            REG_HORIZ_THR:    cfg_in.horiz_thr    = csr_wdata[MG_W-1:0];
            REG_VERT_THR:     cfg_in.vert_thr     = csr_wdata[MG_W-1:0];
            REG_DEPTH_THR:    cfg_in.depth_thr    = csr_wdata[MG_W-1:0];
            REG_HORIZ_MARGIN: cfg_in.horiz_margin = csr_wdata[MG_W-1:0];
            REG_VERT_MARGIN:  cfg_in.vert_margin  = csr_wdata[MG_W-1:0];
            REG_DEPTH_MARGIN: cfg_in.depth_margin = csr_wdata[MG_W-1:0];
            REG_REARM:        cfg_in.rearm        = csr_wdata[MG_W-1:0];
            REG_COOLDOWN:     cfg_in.cooldown     = csr_wdata[COOL_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.horiz_thr    <= RST_THR;
         cfg_ff.vert_thr     <= RST_THR;
         cfg_ff.depth_thr    <= RST_THR;
         cfg_ff.horiz_margin <= RST_MARGIN;
         cfg_ff.vert_margin  <= RST_MARGIN;
         cfg_ff.depth_margin <= RST_MARGIN;
         cfg_ff.rearm        <= RST_REARM;
         cfg_ff.cooldown     <= RST_COOLDOWN;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Classifier.
   sgd_front #(
      .DEPTH_ENABLED(DEPTH_ENABLED)
   ) u_front (
      .cfg      (cfg_ff),
      .req_chan (req_chan),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_data   (q_in_data)
   );

   // Queue between classifier and state stage.
   sgd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  (q_in_data),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_data  (q_head)
   );

   // Arming, cooldown and output stage.
   sgd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cooldown   (cfg_ff.cooldown),
      .head_valid (q_valid),
      .head_data  (q_head),
      .pop        (q_pop),
      .rsp_chan   (rsp_chan)
   );

endmodule

`default_nettype wire
